// ===== sv/trimmed_mean_table_linearizer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// trimmed mean table linearizer assertion macros
// shared property wrappers for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_TABLE_LINEARIZER_UNIT_MACROS_SVH
`define TRIMMED_MEAN_TABLE_LINEARIZER_UNIT_MACROS_SVH

// same-cycle implication
`define TMTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TMTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/tmtl_pkg.sv =====
// ----------------------------------------------------------------------------
// tmtl_pkg
// constants and calibration tables of the trimmed mean table linearizer
// ----------------------------------------------------------------------------
`default_nettype none

package tmtl_pkg;

  localparam int unsigned CAL_POINTS = 41;
  localparam int unsigned CAL_TABLES = 4;
  localparam int unsigned CAL_XW     = 11;
  localparam int unsigned CAL_YW     = 10;
  localparam int unsigned READING_W  = 12;
  localparam int unsigned THR_W      = 12;
  localparam int unsigned SEL_W      = 3;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [SEL_W-1:0] MODE_PASS = 3'd4;
  localparam logic [READING_W-1:0] READING_MAX = 12'd1000;
  localparam int unsigned TRIM_MIN_COUNT = 5;
  localparam int unsigned BLEND_DIVISOR = 5;

  // divide by five as multiply by 838861 and shift by 22, exact below 2^22
  localparam int unsigned BLEND_RECIP_W = 20;
  localparam logic [BLEND_RECIP_W-1:0] BLEND_RECIP = 20'd838861;
  localparam int unsigned BLEND_SHIFT = 22;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SELECT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_THRESHOLD = 2'd2;

  localparam logic [THR_W-1:0] THR_RESET = 12'd20;

  localparam logic [CAL_XW-1:0] CAL_X [CAL_POINTS] = '{
    11'd0, 11'd60, 11'd80, 11'd115, 11'd135, 11'd154, 11'd186, 11'd222, 11'd246,
    11'd288, 11'd324, 11'd357, 11'd399, 11'd431, 11'd435, 11'd466, 11'd477,
    11'd499, 11'd523, 11'd543, 11'd554, 11'd578, 11'd583, 11'd598, 11'd616,
    11'd639, 11'd665, 11'd692, 11'd723, 11'd732, 11'd741, 11'd752, 11'd765,
    11'd782, 11'd802, 11'd827, 11'd861, 11'd911, 11'd1000, 11'd1010, 11'd1030
  };

  localparam logic [CAL_YW-1:0] CAL_Y [CAL_TABLES][CAL_POINTS] = '{
    '{10'd0, 10'd30, 10'd40, 10'd45, 10'd53, 10'd56, 10'd63, 10'd69, 10'd85,
      10'd88, 10'd94, 10'd99, 10'd106, 10'd113, 10'd115, 10'd126, 10'd130,
      10'd136, 10'd144, 10'd153, 10'd156, 10'd163, 10'd167, 10'd173, 10'd183,
      10'd229, 10'd304, 10'd385, 10'd485, 10'd505, 10'd549, 10'd584, 10'd638,
      10'd721, 10'd849, 10'd923, 10'd936, 10'd955, 10'd995, 10'd998, 10'd999},
    '{10'd0, 10'd35, 10'd45, 10'd56, 10'd64, 10'd69, 10'd76, 10'd83, 10'd99,
      10'd102, 10'd108, 10'd113, 10'd121, 10'd128, 10'd130, 10'd144, 10'd149,
      10'd156, 10'd164, 10'd173, 10'd177, 10'd184, 10'd189, 10'd196, 10'd217,
      10'd257, 10'd328, 10'd385, 10'd485, 10'd505, 10'd549, 10'd584, 10'd638,
      10'd721, 10'd849, 10'd923, 10'd936, 10'd955, 10'd995, 10'd998, 10'd999},
    '{10'd0, 10'd45, 10'd50, 10'd62, 10'd72, 10'd77, 10'd84, 10'd92, 10'd112,
      10'd115, 10'd123, 10'd130, 10'd141, 10'd150, 10'd155, 10'd174, 10'd178,
      10'd191, 10'd204, 10'd217, 10'd226, 10'd236, 10'd241, 10'd248, 10'd273,
      10'd309, 10'd349, 10'd385, 10'd485, 10'd505, 10'd549, 10'd584, 10'd638,
      10'd721, 10'd849, 10'd923, 10'd936, 10'd955, 10'd995, 10'd998, 10'd999},
    '{10'd0, 10'd50, 10'd58, 10'd68, 10'd79, 10'd84, 10'd93, 10'd101, 10'd117,
      10'd118, 10'd128, 10'd134, 10'd143, 10'd151, 10'd153, 10'd166, 10'd172,
      10'd180, 10'd191, 10'd205, 10'd211, 10'd222, 10'd227, 10'd233, 10'd255,
      10'd286, 10'd333, 10'd385, 10'd485, 10'd505, 10'd549, 10'd584, 10'd638,
      10'd721, 10'd849, 10'd923, 10'd936, 10'd955, 10'd995, 10'd998, 10'd999}
  };

endpackage

`default_nettype wire

// ===== sv/tmtl_ram.sv =====
// ----------------------------------------------------------------------------
// tmtl_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module tmtl_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/tmtl_div.sv =====
// ----------------------------------------------------------------------------
// tmtl_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tmtl_div #(
  parameter int unsigned DVW = 26,
  parameter int unsigned DSW = 11
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [DVW-1:0] dividend_i,
  input  wire logic [DSW-1:0] divisor_i,
  output      logic           done_o,
  output      logic [DVW-1:0] quotient_o
);

  localparam int unsigned NW = $clog2(DVW + 1);

  logic           busy_q, done_q;
  logic [NW-1:0]  cnt_q;
  logic [DVW-1:0] quo_q;
  logic [DSW-1:0] rem_q, dsr_q;
  logic [DSW:0]   shifted, nrem;
  logic           ge;

  always_comb begin
    shifted = {rem_q, quo_q[DVW-1]};
    ge      = shifted >= {1'b0, dsr_q};
    nrem    = ge ? shifted - {1'b0, dsr_q} : shifted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= NW'(DVW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == NW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVW-2:0], ge};
      rem_q <= nrem[DSW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== sv/trimmed_mean_table_linearizer_unit.sv =====
// ----------------------------------------------------------------------------
// trimmed_mean_table_linearizer_unit
// windowed trimmed mean filter, 3:2 blend and table linearizer for adc words
// ----------------------------------------------------------------------------
// One adc word in, one reading word out. The sample history lives in a
// WINDOW-deep ram used as a ring buffer; each word reads the oldest entry,
// writes the new sample, then walks the held entries one per cycle. A shared
// one-bit-per-cycle divider does the mean and the table interpolation, the
// 3:2 blend divides by five with a reciprocal multiply, and the table segment
// is searched one point per cycle. The walk covers at most WINDOW held
// entries and the search reaches at most segment index 40; a jump skips
// the walk and the mean, passthrough skips the search and the
// interpolation. tready is high only between items.
`default_nettype none

module trimmed_mean_table_linearizer_unit #(
  parameter int unsigned WINDOW      = 16,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  // adc_sample
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // reading
  output      logic [15:0]                          m_axis_tdata,
  input  wire logic                                 cfg_valid_i,
  output      logic                                 cfg_ready_o,
  input  wire logic [tmtl_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [tmtl_pkg::THR_W-1:0]           cfg_data_i
);

  import tmtl_pkg::*;

  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned PW   = $clog2(WINDOW);
  localparam int unsigned CW   = $clog2(WINDOW + 1);
  localparam int unsigned SUMW = SB + CW;
  localparam int unsigned VW   = (SB > CAL_XW) ? SB : CAL_XW;
  localparam int unsigned CMPW = (SB > THR_W) ? SB : THR_W;
  localparam int unsigned DVW  = VW + CAL_YW;
  localparam int unsigned DSW  = CAL_XW;
  localparam int unsigned IW   = $clog2(CAL_POINTS);
  localparam int unsigned BSW  = SB + 3;
  localparam int unsigned BPW  = BSW + BLEND_RECIP_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CMP    = 4'd1;
  localparam logic [3:0] S_WALK   = 4'd2;
  localparam logic [3:0] S_AVG    = 4'd3;
  localparam logic [3:0] S_AVGW   = 4'd4;
  localparam logic [3:0] S_BLEND  = 4'd5;
  localparam logic [3:0] S_BLENDW = 4'd6;
  localparam logic [3:0] S_MAP    = 4'd7;
  localparam logic [3:0] S_SRCH   = 4'd8;
  localparam logic [3:0] S_INT    = 4'd9;
  localparam logic [3:0] S_INTW   = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  function automatic logic [PW-1:0] wrap(input logic [PW:0] a);
    logic [PW:0] b;
    b = (a >= (PW+1)'(WINDOW)) ? a - (PW+1)'(WINDOW) : a;
    return b[PW-1:0];
  endfunction

  logic [3:0]           state_q, state_d;
  logic [SEL_W-1:0]     tsel_q;
  logic [THR_W-1:0]     jthr_q, bthr_q;
  logic [SB-1:0]        samp_q, samp_d, val_q, val_d, prev_q, prev_d;
  logic [SB-1:0]        hi_q, hi_d, lo_q, lo_d;
  logic [SUMW-1:0]      sum_q, sum_d;
  logic [PW-1:0]        head_q, head_d;
  logic [CW-1:0]        cnt_q, cnt_d, k_q, k_d, nrecv_q, nrecv_d;
  logic                 rv_q, rv_d;
  logic [IW-1:0]        idx_q, idx_d, idx_m1;
  logic [DVW-1:0]       prod_q, prod_d;
  logic [READING_W-1:0] res_q, res_d, out_q;
  logic                 ovalid_q;

  logic                 we;
  logic [PW-1:0]        waddr, raddr;
  logic [SB-1:0]        rdata, old;
  logic [SB-1:0]        adiff;
  logic                 div_start, div_done;
  logic [DVW-1:0]       div_dvd, div_q;
  logic [DSW-1:0]       div_dsr;
  logic [VW-1:0]        dx;
  logic [CAL_YW-1:0]    dy;
  logic [DVW:0]         ysum;
  logic [BPW-1:0]       bprod;
  logic                 out_load;

  tmtl_ram #(.WIDTH(SB), .DEPTH(WINDOW)) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (samp_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tmtl_div #(.DVW(DVW), .DSW(DSW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign old    = (cnt_q == '0) ? '0 : rdata;
  assign idx_m1 = idx_q - 1'b1;
  assign out_load = (state_q == S_OUT) && (!ovalid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    samp_d    = samp_q;
    val_d     = val_q;
    prev_d    = prev_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    sum_d     = sum_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    nrecv_d   = nrecv_q;
    rv_d      = 1'b0;
    idx_d     = idx_q;
    prod_d    = prod_q;
    res_d     = res_q;
    we        = 1'b0;
    waddr     = head_q;
    raddr     = head_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    adiff     = '0;
    dx        = '0;
    dy        = '0;
    ysum      = '0;
    bprod     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          samp_d  = s_axis_tdata[SB-1:0];
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        adiff = (samp_q > old) ? samp_q - old : old - samp_q;
        we    = 1'b1;
        if (CMPW'(adiff) >= CMPW'(jthr_q)) begin
          cnt_d   = CW'(1);
          val_d   = samp_q;
          state_d = S_BLEND;
        end else begin
          if (cnt_q == CW'(WINDOW)) begin
            head_d = wrap((PW+1)'(head_q) + (PW+1)'(1));
          end else begin
            waddr = wrap((PW+1)'(head_q) + (PW+1)'(cnt_q));
            cnt_d = cnt_q + 1'b1;
          end
          k_d     = '0;
          nrecv_d = '0;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        raddr = wrap((PW+1)'(head_q) + (PW+1)'(k_q));
        if (k_q < cnt_q) begin
          k_d  = k_q + 1'b1;
          rv_d = 1'b1;
        end
        if (rv_q) begin
          nrecv_d = nrecv_q + 1'b1;
          if (nrecv_q == '0) begin
            sum_d = SUMW'(rdata);
            hi_d  = rdata;
            lo_d  = rdata;
          end else begin
            sum_d = sum_q + SUMW'(rdata);
            if (rdata > hi_q) hi_d = rdata;
            if (rdata < lo_q) lo_d = rdata;
          end
          if (nrecv_q + 1'b1 == cnt_q) begin
            rv_d    = 1'b0;
            state_d = S_AVG;
          end
        end
      end
      S_AVG: begin
        div_start = 1'b1;
        if (cnt_q < CW'(TRIM_MIN_COUNT)) begin
          div_dvd = DVW'(sum_q);
          div_dsr = DSW'(cnt_q);
        end else begin
          div_dvd = DVW'(sum_q - SUMW'(hi_q) - SUMW'(lo_q));
          div_dsr = DSW'(cnt_q - CW'(2));
        end
        state_d = S_AVGW;
      end
      S_AVGW: begin
        if (div_done) begin
          val_d   = div_q[SB-1:0];
          state_d = S_BLEND;
        end
      end
      S_BLEND: begin
        adiff = (val_q > prev_q) ? val_q - prev_q : prev_q - val_q;
        if (CMPW'(adiff) < CMPW'(bthr_q)) begin
          prod_d  = DVW'(BSW'(3) * BSW'(prev_q) + BSW'(2) * BSW'(val_q));
          state_d = S_BLENDW;
        end else begin
          prev_d  = val_q;
          state_d = S_MAP;
        end
      end
      S_BLENDW: begin
        bprod   = BPW'(prod_q[BSW-1:0]) * BPW'(BLEND_RECIP);
        val_d   = bprod[BLEND_SHIFT +: SB];
        prev_d  = bprod[BLEND_SHIFT +: SB];
        state_d = S_MAP;
      end
      S_MAP: begin
        idx_d = '0;
        if (tsel_q >= MODE_PASS) begin
          res_d   = READING_W'(val_q);
          state_d = S_OUT;
        end else begin
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if ((idx_q < IW'(CAL_POINTS - 1)) && (VW'(val_q) > VW'(CAL_X[idx_q]))) begin
          idx_d = idx_q + 1'b1;
        end else if (idx_q == '0) begin
          res_d   = '0;
          state_d = S_OUT;
        end else begin
          dx      = VW'(val_q) - VW'(CAL_X[idx_m1]);
          dy      = CAL_Y[tsel_q[1:0]][idx_q] - CAL_Y[tsel_q[1:0]][idx_m1];
          prod_d  = {{CAL_YW{1'b0}}, dx} * {{VW{1'b0}}, dy};
          state_d = S_INT;
        end
      end
      S_INT: begin
        div_start = 1'b1;
        div_dvd   = prod_q;
        div_dsr   = CAL_X[idx_q] - CAL_X[idx_m1];
        state_d   = S_INTW;
      end
      S_INTW: begin
        if (div_done) begin
          ysum = (DVW+1)'(CAL_Y[tsel_q[1:0]][idx_m1]) + (DVW+1)'(div_q);
          res_d = (ysum >= (DVW+1)'(READING_MAX)) ? READING_MAX : ysum[READING_W-1:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tsel_q   <= '0;
      jthr_q   <= THR_RESET;
      bthr_q   <= THR_RESET;
      prev_q   <= '0;
      head_q   <= '0;
      cnt_q    <= '0;
      k_q      <= '0;
      nrecv_q  <= '0;
      rv_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      prev_q  <= prev_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      nrecv_q <= nrecv_d;
      rv_q    <= rv_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_TABLE_SELECT:    tsel_q <= cfg_data_i[SEL_W-1:0];
          REG_JUMP_THRESHOLD:  jthr_q <= cfg_data_i;
          REG_BLEND_THRESHOLD: bthr_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q <= samp_d;
    val_q  <= val_d;
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    sum_q  <= sum_d;
    idx_q  <= idx_d;
    prod_q <= prod_d;
    res_q  <= res_d;
    if (out_load) out_q <= res_q;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {{(16-READING_W){1'b0}}, out_q};
  assign cfg_ready_o   = 1'b1;

`include "trimmed_mean_table_linearizer_unit_macros.svh"

  `TMTL_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CW'(WINDOW), "history count beyond window")
  `TMTL_ASSERT_NOW(a_head_range, 1'b1, (PW+1)'(head_q) < (PW+1)'(WINDOW),
    "ring head out of range")
  `TMTL_ASSERT_NEXT(a_accept_cmp, s_axis_tvalid && s_axis_tready, state_q == S_CMP,
    "accepted word did not start compare")
  `TMTL_ASSERT_NEXT(a_out_load, out_load, m_axis_tvalid && (state_q == S_IDLE),
    "result not presented after load")

endmodule

`default_nettype wire

// ===== tb/trimmed_mean_table_linearizer_unit_test.sv =====
// ----------------------------------------------------------------------------
// trimmed_mean_table_linearizer_unit_test
// drives adc words with random stalls on both sides through several register
// settings, predicts the window filter, blend and table lookup for every
// accepted word and compares each reading word in order
// ----------------------------------------------------------------------------
`default_nettype none

module trimmed_mean_table_linearizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tmtl_pkg::*;

  localparam logic [SEL_W-1:0] TAB_A = 3'd0;
  localparam logic [SEL_W-1:0] TAB_B = 3'd1;
  localparam logic [SEL_W-1:0] TAB_C = 3'd2;
  localparam logic [SEL_W-1:0] TAB_D = 3'd3;
  localparam logic [SEL_W-1:0] TAB_SPARE = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HIST_DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;
  typedef struct {
    row_kind_e kind;
    logic [CFG_IDX_W-1:0] idx;
    int value;
    int typed_reading;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [THR_W-1:0] cfg_data_i = '0;

  trimmed_mean_table_linearizer_unit uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // predictor state
  logic [SEL_W-1:0] p_sel;
  logic [THR_W-1:0] p_jump_thr;
  logic [THR_W-1:0] p_blend_thr;
  int p_hist [HIST_DEPTH];
  int p_count;
  int p_prev;

  logic [READING_W-1:0] pending_readings [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit no_idling = 0;
  bit stall_request = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int abs_diff(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic int filter_window(int s);
    int sum, hi, lo;
    if (abs_diff(s, p_hist[0]) >= p_jump_thr) begin
      p_hist[0] = s;
      p_count = 1;
      return s;
    end
    if (p_count >= HIST_DEPTH) begin
      for (int k = 0; k < HIST_DEPTH - 1; k++) p_hist[k] = p_hist[k + 1];
    end else begin
      p_count++;
    end
    p_hist[p_count - 1] = s;
    sum = 0;
    hi = p_hist[0];
    lo = p_hist[0];
    for (int k = 0; k < p_count; k++) begin
      sum += p_hist[k];
      if (p_hist[k] > hi) hi = p_hist[k];
      if (p_hist[k] < lo) lo = p_hist[k];
    end
    if (p_count < TRIM_MIN_COUNT) return sum / p_count;
    return (sum - hi - lo) / (p_count - 2);
  endfunction

  function automatic int calibrate(int t, int v);
    int i, x0, x1, y0, y1, r;
    i = 0;
    while (i < CAL_POINTS - 1 && v > CAL_X[i]) i++;
    if (i == 0) return 0;
    x0 = CAL_X[i - 1];
    x1 = CAL_X[i];
    y0 = CAL_Y[t][i - 1];
    y1 = CAL_Y[t][i];
    r = y0 + ((v - x0) * (y1 - y0)) / (x1 - x0);
    return r >= READING_MAX ? READING_MAX : r;
  endfunction

  function automatic logic [READING_W-1:0] predict_reading(int s);
    int v;
    v = filter_window(s);
    if (abs_diff(v, p_prev) < p_blend_thr) v = (3 * p_prev + 2 * v) / BLEND_DIVISOR;
    p_prev = v;
    if (p_sel < MODE_PASS) return READING_W'(calibrate(p_sel, v));
    return READING_W'(v);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    s_axis_tvalid <= 1'b0;
    wait (pending_readings.size() == 0);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= THR_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_TABLE_SELECT: p_sel = SEL_W'(value);
      REG_JUMP_THRESHOLD: p_jump_thr = THR_W'(value);
      REG_BLEND_THRESHOLD: p_blend_thr = THR_W'(value);
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_sample(int s, int typed_reading);
    logic [READING_W-1:0] r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= 16'(s);
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_reading(s);
    pending_readings.push_back(typed_reading >= 0 ? READING_W'(typed_reading) : r);
    if (!no_idling && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  function automatic int next_sample(int base, int spread);
    int s;
    case ($urandom_range(0, 19))
      0: s = $urandom_range(0, 4095);
      1: s = base + $urandom_range(0, 400);
      default: s = base + int'($urandom_range(0, 2 * spread)) - spread;
    endcase
    if (s < 0) s = 0;
    if (s > 4095) s = 4095;
    return s;
  endfunction

  // reading word receiver
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (stall_request && hold == 0) begin
        stall_request = 0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 16);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reading word %0d", m_axis_tdata);
      end else begin
        logic [READING_W-1:0] want;
        want = pending_readings.pop_front();
        if (m_axis_tdata !== {4'b0, want}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reading mismatch: expected %0d, got %0d", want, m_axis_tdata);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("trimmed_mean_table_linearizer_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  stim_row_t directed [] = '{
    '{ROW_SAMPLE, REG_TABLE_SELECT, 0, 0},
    '{ROW_WRITE, REG_JUMP_THRESHOLD, 0, -1},
    '{ROW_SAMPLE, REG_TABLE_SELECT, 4095, 1000},
    '{ROW_WRITE, REG_TABLE_SELECT, MODE_PASS, -1},
    '{ROW_SAMPLE, REG_TABLE_SELECT, 4095, 4095},
    '{ROW_WRITE, REG_BLEND_THRESHOLD, 0, -1},
    '{ROW_SAMPLE, REG_TABLE_SELECT, 0, 0},
    '{ROW_WRITE, REG_TABLE_SELECT, TAB_SPARE, -1},
    '{ROW_SAMPLE, REG_TABLE_SELECT, 1234, 1234},
    '{ROW_WRITE, REG_UNUSED, 4095, -1},
    '{ROW_SAMPLE, REG_TABLE_SELECT, 5, 5},
    '{ROW_WRITE, REG_JUMP_THRESHOLD, 4095, -1},
    '{ROW_WRITE, REG_BLEND_THRESHOLD, 4095, -1},
    '{ROW_WRITE, REG_TABLE_SELECT, TAB_A, -1},
    '{ROW_SAMPLE, REG_TABLE_SELECT, 100, -1},
    '{ROW_SAMPLE, REG_TABLE_SELECT, 60, -1},
    '{ROW_SAMPLE, REG_TABLE_SELECT, 1030, -1},
    '{ROW_SAMPLE, REG_TABLE_SELECT, 2730, -1},
    '{ROW_SAMPLE, REG_TABLE_SELECT, 1365, -1},
    '{ROW_SAMPLE, REG_TABLE_SELECT, 500, -1},
    '{ROW_WRITE, REG_TABLE_SELECT, TAB_B, -1},
    '{ROW_SAMPLE, REG_TABLE_SELECT, 640, -1},
    '{ROW_WRITE, REG_TABLE_SELECT, TAB_C, -1},
    '{ROW_SAMPLE, REG_TABLE_SELECT, 300, -1},
    '{ROW_WRITE, REG_TABLE_SELECT, TAB_D, -1},
    '{ROW_SAMPLE, REG_TABLE_SELECT, 1010, -1},
    '{ROW_SAMPLE, REG_TABLE_SELECT, 20, -1}
  };

  initial begin
    int base, spread, thr;
    p_sel = TAB_A;
    p_jump_thr = THR_RESET;
    p_blend_thr = THR_RESET;
    foreach (p_hist[k]) p_hist[k] = 0;
    p_count = 0;
    p_prev = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[n]) begin
      if (directed[n].kind == ROW_WRITE) write_reg(directed[n].idx, directed[n].value);
      else send_sample(directed[n].value, directed[n].typed_reading);
    end

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_TABLE_SELECT, TAB_A);
          write_reg(REG_JUMP_THRESHOLD, 1);
          write_reg(REG_BLEND_THRESHOLD, 1);
        end
        1: begin
          write_reg(REG_TABLE_SELECT, TAB_D);
          write_reg(REG_JUMP_THRESHOLD, 4095);
          write_reg(REG_BLEND_THRESHOLD, 4095);
        end
        default: begin
          write_reg(REG_TABLE_SELECT, $urandom_range(0, 7));
          thr = $urandom_range(0, 1) ? $urandom_range(1, 60) : $urandom_range(1, 4095);
          write_reg(REG_JUMP_THRESHOLD, thr);
          write_reg(REG_BLEND_THRESHOLD, $urandom_range(0, 1) ? $urandom_range(1, 60)
                                                              : $urandom_range(1, 4095));
        end
      endcase
      if (phase == 7) no_idling = 1;
      base = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 1100);
      for (int n = 0; n < 225; n++) begin
        if (phase == 2 && n == 50) stall_request = 1;
        if ($urandom_range(0, 39) == 0)
          base = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                           : $urandom_range(0, 1100);
        spread = p_jump_thr > 2 ? p_jump_thr / 2 : 1;
        if (spread > 200) spread = 200;
        send_sample(next_sample(base, spread), -1);
      end
    end
    s_axis_tvalid <= 1'b0;

    wait (pending_readings.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("trimmed_mean_table_linearizer_unit test passed");
    end else begin
      $display("trimmed_mean_table_linearizer_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
